[rtl/min_priority_queue_assert.svh]
`ifndef MIN_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mpq_pkg.sv]
package mpq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_W      = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_NOP    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MIN
  } mpq_state_t;

endpackage

[rtl/mpq_in_if.sv]
interface mpq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           req_type;
  logic signed [mpq_pkg::DATA_W-1:0]    value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

[rtl/mpq_out_if.sv]
interface mpq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mpq_pkg::DATA_W-1:0]    result_value;
  logic [1:0]                           status;
  logic [mpq_pkg::COUNT_W-1:0]          count;

  modport source (output valid, output result_value, output status, output count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input count,
                  output ready);
endinterface

[rtl/mpq_store.sv]
module mpq_store #(
  parameter int unsigned DEPTH  = mpq_pkg::CAPACITY_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned DATA_W = mpq_pkg::DATA_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/min_priority_queue.sv]
// Bounded min-priority queue of signed 32-bit values, kept in ascending order in a
// circular buffer in one memory (one write and one registered read per cycle). A
// remove or peek on a non-empty queue reads the head, then gives the result; a
// no-op, an insert into an empty queue and any error need no memory read; an
// insert into a non-empty queue walks down from the tail, moving each held entry
// greater than the value up one place, one entry per cycle through the single
// memory port, and then writes the value. Equal values are placed
// after those already held. One request is in work at a time; its result sits in
// an output register and the next request is taken once that register can be
// freed. No clearing pass follows reset: only entries below the count are read.
module min_priority_queue #(
  parameter int unsigned CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  mpq_in_if.sink          in_ch,
  mpq_out_if.source       out_ch
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DW    = mpq_pkg::DATA_W;
  localparam int unsigned OCW   = mpq_pkg::COUNT_W;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
    logic [IDX_W:0] r;
    r = s;
    if (s >= (IDX_W+1)'(CAPACITY)) begin
      r = s - (IDX_W+1)'(CAPACITY);
    end
    return r[IDX_W-1:0];
  endfunction

  mpq_pkg::mpq_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    wpos_r, wpos_nxt;
  logic signed [DW-1:0] val_r, val_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_value_r, out_value_nxt;
  mpq_pkg::status_t     out_status_r, out_status_nxt;
  logic [OCW-1:0]       out_count_r, out_count_nxt;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0]    mem_wdata, mem_rd_data;

  logic              out_free, accept, is_full, is_empty;
  logic [IDX_W-1:0]  cnt_idx;
  logic [CNT_W-1:0]  cnt_inc, cnt_dec;
  mpq_pkg::req_kind_t kind;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == mpq_pkg::S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ch.ready;
  assign kind     = mpq_pkg::req_kind_t'(in_ch.req_type);
  assign is_full  = (cnt_r == CNT_W'(CAPACITY));
  assign is_empty = (cnt_r == '0);
  assign cnt_idx  = IDX_W'(cnt_r);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_dec  = cnt_r - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    wpos_nxt       = wpos_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = val_r;
    mem_re         = 1'b0;
    mem_raddr      = head_r;

    unique case (state_r)
      mpq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (kind)
            mpq_pkg::REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_value_nxt  = '0;
                out_status_nxt = mpq_pkg::ST_FULL;
                out_count_nxt  = OCW'(cnt_r);
              end else begin
                out_value_nxt  = in_ch.value;
                out_status_nxt = mpq_pkg::ST_OK;
                out_count_nxt  = OCW'(cnt_inc);
                cnt_nxt        = cnt_inc;
                val_nxt        = in_ch.value;
                if (is_empty) begin
                  mem_we    = 1'b1;
                  mem_waddr = head_r;
                  mem_wdata = in_ch.value;
                end else begin
                  // start the walk at the tail entry
                  mem_re    = 1'b1;
                  mem_raddr = wrap_idx({1'b0, head_r} + {1'b0, cnt_idx - IDX_W'(1)});
                  wpos_nxt  = cnt_idx;
                  state_nxt = mpq_pkg::S_SCAN;
                end
              end
            end
            mpq_pkg::REQ_REMOVE, mpq_pkg::REQ_PEEK: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = mpq_pkg::ST_EMPTY;
                out_count_nxt  = OCW'(cnt_r);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = mpq_pkg::S_MIN;
                if (kind == mpq_pkg::REQ_REMOVE) begin
                  head_nxt = wrap_idx({1'b0, head_r} + (IDX_W+1)'(1));
                  cnt_nxt  = cnt_dec;
                end
              end
            end
            mpq_pkg::REQ_NOP: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = mpq_pkg::ST_OK;
              out_count_nxt  = OCW'(cnt_r);
            end
          endcase
        end
      end

      mpq_pkg::S_MIN: begin
        // output slot was free at accept and nothing was loaded since
        out_valid_nxt  = 1'b1;
        out_value_nxt  = mem_rd_data;
        out_status_nxt = mpq_pkg::ST_OK;
        out_count_nxt  = OCW'(cnt_r);
        state_nxt      = mpq_pkg::S_IDLE;
      end

      mpq_pkg::S_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = wrap_idx({1'b0, head_r} + {1'b0, wpos_r});
        if (wpos_r == '0) begin
          mem_wdata = val_r;
          state_nxt = mpq_pkg::S_IDLE;
        end else if ($signed(mem_rd_data) > val_r) begin
          // move the larger entry up one place, fetch the next one down
          mem_wdata = mem_rd_data;
          wpos_nxt  = wpos_r - IDX_W'(1);
          if (wpos_r != IDX_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = wrap_idx({1'b0, head_r} + {1'b0, wpos_r - IDX_W'(2)});
          end
        end else begin
          mem_wdata = val_r;
          state_nxt = mpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpq_pkg::S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wpos_r       <= wpos_nxt;
    val_r        <= val_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  mpq_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (DW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rd_data (mem_rd_data)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.count        = out_count_r;

endmodule

[rtl/mpq_checker.sv]
`include "min_priority_queue_assert.svh"

module mpq_checker #(
  parameter int unsigned CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mpq_pkg::DATA_W-1:0] out_result_value,
  input logic [1:0]                        out_status,
  input logic [mpq_pkg::COUNT_W-1:0]       out_count
);

  // stalled result holds until taken
  `MPQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_value) && $stable(out_status) && $stable(out_count), "stalled result changed")

  // empty error reports zero value and zero entries
  `MPQ_ASSERT_IMP(a_empty_zero, out_valid && (out_status == mpq_pkg::ST_EMPTY), (out_result_value == '0) && (out_count == '0), "empty result not zero")

  // dropped insert happens only at capacity
  `MPQ_ASSERT_IMP(a_full_cap, out_valid && (out_status == mpq_pkg::ST_FULL), (out_result_value == '0) && (out_count == mpq_pkg::COUNT_W'(CAPACITY)), "full result inconsistent")

  // count never exceeds capacity
  `MPQ_ASSERT_IMP(a_count_max, out_valid, (CAPACITY > 31) || (out_count <= mpq_pkg::COUNT_W'(CAPACITY)), "count above capacity")

endmodule

bind min_priority_queue mpq_checker #(
  .CAPACITY (CAPACITY)
) u_mpq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value),
  .out_status       (out_ch.status),
  .out_count        (out_ch.count)
);

[bench/min_priority_queue_tb.sv]
module min_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int          TOTAL_REQS = 850;
  localparam int          QUIET_TAIL = 100;
  localparam int          HOLD_CYCLES = 200;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_CYCLES = 40;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } req_mix_t;
  typedef enum int { VAL_FULL, VAL_NARROW, VAL_EDGES } val_mix_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } pq_result_t;

  class pq_scoreboard;
    logic signed [DATA_W-1:0] held[$];
    pq_result_t               awaited[$];
    int                       failures = 0;

    // Track the sorted contents and queue up the response this request should produce.
    function void note_request(req_kind_t kind, logic signed [DATA_W-1:0] val);
      pq_result_t want;
      int         pos;
      want.value  = '0;
      want.status = ST_OK;
      case (kind)
        REQ_INSERT: begin
          if (held.size() >= CAP) begin
            want.status = ST_FULL;
          end else begin
            // equal values go after the ones already held
            pos = 0;
            while (pos < held.size() && held[pos] <= val) pos++;
            held.insert(pos, val);
            want.value = val;
          end
        end
        REQ_REMOVE, REQ_PEEK: begin
          if (held.size() == 0) begin
            want.status = ST_EMPTY;
          end else begin
            want.value = held[0];
            if (kind == REQ_REMOVE) void'(held.pop_front());
          end
        end
        default: ;
      endcase
      want.count = COUNT_W'(held.size());
      awaited.push_back(want);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] val, logic [1:0] st,
                               logic [COUNT_W-1:0] cnt);
      pq_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: result_value %0d status %0d count %0d",
               $signed(val), st, cnt);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (val !== want.value) begin
        $error("result_value: expected %0d, got %0d", $signed(want.value), $signed(val));
        failures++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        failures++;
      end
      if (cnt !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, cnt);
        failures++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet;
  logic long_hold;
  int   sent;

  pq_scoreboard sb;

  mpq_in_if  in_ch ();
  mpq_out_if out_ch ();

  min_priority_queue #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_value, out_ch.status, out_ch.count);
  end

  // Stall detector: end the run if no transaction moves for too long.
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("min_priority_queue_tb NOT OK");
    $finish;
  end

  // Result side back-pressure.
  initial begin
    int stall_pct;
    int span;
    out_ch.ready = 1'b0;
    stall_pct = 10;
    span = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (span == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
        span = 64;
      end
      span--;
      if (long_hold) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_request(input req_kind_t kind, input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.req_type = kind;
    in_ch.value    = val;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(kind, val);
    sent++;
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk);
    in_ch.valid    = 1'b0;
    in_ch.req_type = 2'($urandom);
    in_ch.value    = $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold off the sender until every outstanding response has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic req_kind_t pick_kind(req_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return roll < 75 ? REQ_INSERT : roll < 87 ? REQ_REMOVE :
                        roll < 95 ? REQ_PEEK : REQ_NOP;
      MIX_DRAIN: return roll < 65 ? REQ_REMOVE : roll < 82 ? REQ_INSERT :
                        roll < 94 ? REQ_PEEK : REQ_NOP;
      default:   return roll < 40 ? REQ_INSERT : roll < 75 ? REQ_REMOVE :
                        roll < 92 ? REQ_PEEK : REQ_NOP;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(val_mix_t mix);
    case (mix)
      VAL_NARROW: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      VAL_EDGES: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(DATA_W-1){1'b0}}};
          1: return {1'b0, {(DATA_W-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    req_mix_t mix;
    val_mix_t vmix;
    int       len;
    logic     sender_idles;
    logic     hold_done;

    sb = new();
    rst_n          = 1'b0;
    quiet          = 1'b0;
    long_hold      = 1'b0;
    hold_done      = 1'b0;
    sent           = 0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_NOP;
    in_ch.value    = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty queue: remove and peek flag empty, no-op does nothing
    send_request(REQ_REMOVE, 32'sd5);
    send_request(REQ_PEEK, 32'sd5);
    send_request(REQ_NOP, 32'sd7);
    send_request(REQ_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
    send_request(REQ_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
    send_request(REQ_INSERT, '0);
    send_request(REQ_INSERT, '1);
    send_request(REQ_INSERT, '1);
    send_request(REQ_PEEK, '0);
    send_request(REQ_REMOVE, '0);
    send_request(REQ_NOP, '1);
    // fill to capacity, then insert into a full queue
    for (int k = 0; k < 12; k++) send_request(REQ_INSERT, $urandom);
    send_request(REQ_INSERT, 32'sd3);
    send_request(REQ_PEEK, '0);
    wait_for_drain();

    while (sent < TOTAL_REQS) begin
      mix  = req_mix_t'($urandom_range(0, 2));
      vmix = val_mix_t'($urandom_range(0, 2));
      len  = $urandom_range(10, 40);
      sender_idles = ($urandom_range(0, 2) != 0);
      if (sent >= TOTAL_REQS - QUIET_TAIL) quiet = 1'b1;
      if (!hold_done && sent >= 300) begin
        // keep offering requests while the result side is held off
        long_hold    = 1'b1;
        hold_done    = 1'b1;
        sender_idles = 1'b0;
      end
      for (int k = 0; k < len && sent < TOTAL_REQS; k++) begin
        if (sender_idles && !quiet && $urandom_range(0, 7) == 0)
          sender_gap($urandom_range(1, 13));
        send_request(pick_kind(mix), pick_value(vmix));
      end
      if (!quiet && $urandom_range(0, 3) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("min_priority_queue_tb OK");
    else
      $display("min_priority_queue_tb NOT OK");
    $finish;
  end
endmodule
